// File: src/mcfe_pkg.sv
// Shared types, constants and frame-building functions for the motor command frame encoder.
package mcfe_pkg;

    localparam int MAX_BYTES = 17;
    localparam int IDX_W     = $clog2(MAX_BYTES);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] GUARD_BYTE = 8'h00;
    localparam logic [7:0] FRAME_HEAD = 8'hFB;
    localparam logic [7:0] FRAME_BUS  = 8'h03;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_XOROUT = 8'h55;

    localparam logic signed [15:0] SPEED_MAX = 16'sd140;
    localparam logic signed [15:0] SPEED_MIN = -16'sd140;
    localparam logic [7:0] SPEED_LO_MAX = 8'd140;
    localparam logic [7:0] SPEED_LO_MIN = 8'd116;

    // length, command and register address bytes of the frame
    localparam logic [7:0] LEN_SHORT  = 8'h06;
    localparam logic [7:0] LEN_WRITE  = 8'h08;
    localparam logic [7:0] LEN_TURN   = 8'h0C;
    localparam logic [7:0] OP_READ    = 8'h05;
    localparam logic [7:0] OP_WRITE   = 8'h06;
    localparam logic [7:0] ADDR_QUERY = 8'h09;
    localparam logic [7:0] ADDR_SPEED = 8'h07;
    localparam logic [7:0] ADDR_ID    = 8'h03;
    localparam logic [7:0] ADDR_STOP  = 8'h06;
    localparam logic [7:0] ADDR_TURN  = 8'h04;

    typedef enum logic [2:0] {
        KIND_QUERY     = 3'd0,
        KIND_SET_ID    = 3'd1,
        KIND_TURN      = 3'd2,
        KIND_STOP      = 3'd3,
        KIND_GET_SPEED = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  device_id;
        logic [7:0]  new_id;
        logic [7:0]  speed_hi;
        logic [7:0]  speed_lo;
        logic [15:0] run_time;
    } desc_t;

    // index of the CRC byte in the stream
    function automatic logic [IDX_W-1:0] last_index(input cmd_kind_t kind);
        logic [IDX_W-1:0] r;
        case (kind)
            KIND_SET_ID, KIND_STOP: r = IDX_W'(12);
            KIND_TURN:              r = IDX_W'(16);
            default:                r = IDX_W'(10);
        endcase
        return r;
    endfunction

    // payload byte at a stream offset (CRC slot not covered)
    function automatic logic [7:0] frame_byte(input desc_t d, input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            IDX_W'(0): b = GUARD_BYTE;
            IDX_W'(1): b = FRAME_HEAD;
            IDX_W'(2): b = FRAME_BUS;
            IDX_W'(5): b = d.device_id;
            default:
            begin
                case (d.kind)
                    KIND_QUERY, KIND_GET_SPEED:
                    begin
                        case (idx)
                            IDX_W'(3): b = LEN_SHORT;
                            IDX_W'(4): b = OP_READ;
                            IDX_W'(7): b = (d.kind == KIND_QUERY) ? ADDR_QUERY : ADDR_SPEED;
                            IDX_W'(9): b = (d.kind == KIND_QUERY) ? 8'h05 : 8'h01;
                            default:   b = 8'h00;
                        endcase
                    end
                    KIND_SET_ID, KIND_STOP:
                    begin
                        case (idx)
                            IDX_W'(3):  b = LEN_WRITE;
                            IDX_W'(4):  b = OP_WRITE;
                            IDX_W'(7):  b = (d.kind == KIND_SET_ID) ? ADDR_ID : ADDR_STOP;
                            IDX_W'(9):  b = 8'h01;
                            IDX_W'(11): b = (d.kind == KIND_SET_ID) ? d.new_id : 8'h00;
                            default:    b = 8'h00;
                        endcase
                    end
                    KIND_TURN:
                    begin
                        case (idx)
                            IDX_W'(3):  b = LEN_TURN;
                            IDX_W'(4):  b = OP_WRITE;
                            IDX_W'(7):  b = ADDR_TURN;
                            IDX_W'(9):  b = 8'h03;
                            IDX_W'(10): b = d.speed_hi;
                            IDX_W'(11): b = d.speed_lo;
                            IDX_W'(12): b = d.run_time[15:8];
                            IDX_W'(13): b = d.run_time[7:0];
                            IDX_W'(15): b = 8'h01;
                            default:    b = 8'h00;
                        endcase
                    end
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

    // CRC-8, MSB first, one byte folded in
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// File: src/mcfe_front.sv
// Front end: takes command requests, drops unknown types, clamps speed, builds descriptors.
module mcfe_front (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,
    input  logic [2:0]        s_tuser,
    input  logic              q_full,
    output logic              push,
    output mcfe_pkg::desc_t   push_desc
);
    import mcfe_pkg::*;

    logic signed [15:0] speed;
    logic               kind_ok;

    assign speed    = s_tdata[31:16];
    assign kind_ok  = (s_tuser <= KIND_GET_SPEED);
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready && kind_ok;

    always_comb
    begin
        push_desc.kind      = cmd_kind_t'(s_tuser);
        push_desc.device_id = s_tdata[7:0];
        push_desc.new_id    = s_tdata[15:8];
        push_desc.run_time  = s_tdata[47:32];
        push_desc.speed_hi  = {8{speed[15]}};
        if (speed < SPEED_MIN)
        begin
            push_desc.speed_lo = SPEED_LO_MIN;
        end
        else if (speed > SPEED_MAX)
        begin
            push_desc.speed_lo = SPEED_LO_MAX;
        end
        else
        begin
            push_desc.speed_lo = speed[7:0];
        end
    end

endmodule

// File: src/mcfe_queue.sv
// Small descriptor queue between front end and serializer.
module mcfe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcfe_pkg::desc_t   push_desc,
    input  logic              pop,
    output mcfe_pkg::desc_t   head,
    output logic              empty,
    output logic              full
);
    import mcfe_pkg::*;

    desc_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: src/mcfe_back.sv
// Serializer: sends the head descriptor a byte per cycle unless stalled, folds in CRC, registers output.
module mcfe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mcfe_pkg::desc_t   head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast
);
    import mcfe_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       crc_reg, crc_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic             m_tlast_reg;
    logic             emit;
    logic             at_end;
    logic [7:0]       body_byte;
    logic [7:0]       out_byte;

    assign emit      = !empty && (!m_tvalid_reg || m_tready);
    assign at_end    = (idx_reg == last_index(head.kind));
    assign body_byte = frame_byte(head, idx_reg);
    assign out_byte  = at_end ? (crc_reg ^ CRC_XOROUT) : body_byte;
    assign pop       = emit && at_end;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb
    begin
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            if (at_end)
            begin
                idx_next = '0;
                crc_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                // guard byte and header start stay out of the CRC
                crc_next = (idx_reg >= IDX_W'(2)) ? crc8_step(crc_reg, body_byte) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            crc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= out_byte;
            m_tlast_reg <= at_end;
        end
    end

endmodule

// File: src/motor_command_frame_encoder.sv
// Top level of the motor command frame encoder: front end, descriptor queue, serializer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  s_*     | in        | s_tvalid / s_tready  | tuser: req_type; tdata: device_id, new_id,
//          |           |                      |   speed, run_time
//  m_*     | out       | m_tvalid / m_tready  | tdata: tx_byte; tlast: last (CRC byte)
//
// One byte leaves per cycle unless m_tready stalls: a command is 11, 13 or 17 bytes
// (query and get speed, set id and stop, turn), set by the serializer's byte counter.
// Requests enter while a two-entry queue has room, so the next command is taken during
// the current stream. Unknown request types are accepted and dropped.
// rst_n is asynchronous, active low, and clears queue pointers, byte counter, CRC and
// output valid. A stall on m_tready holds the output register and the serializer.
module motor_command_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // device_id[7:0], new_id[15:8], speed[31:16], run_time[47:32]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // tx_byte[7:0]
    output logic        m_tlast
);
    import mcfe_pkg::*;

    logic  push;
    logic  pop;
    logic  q_empty;
    logic  q_full;
    desc_t push_desc;
    desc_t head;

    mcfe_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    mcfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    mcfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !q_empty)
        else $error("queue empty after a push");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && m_tlast))
        else $error("descriptor retired without a last byte");

    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && (s_tuser > KIND_GET_SPEED)) |-> !push)
        else $error("unknown request type queued");
`endif

endmodule
